// ===== src/small_language_lexer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// small_language_lexer_unit assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SMALL_LANGUAGE_LEXER_UNIT_ASSERT_SVH
`define SMALL_LANGUAGE_LEXER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SLXU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("slxu check failed");
`define SLXU_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("slxu forbidden condition");
`else
`define SLXU_ASSERT(lbl, clk, rst, prop)
`define SLXU_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== src/slxu_pkg.sv =====
// ----------------------------------------------------------------------------
// slxu_pkg
// Token kinds and token record types shared by the lexer unit.
// ----------------------------------------------------------------------------
package slxu_pkg;

   localparam logic [4:0] KIND_LPAREN    = 5'd0;
   localparam logic [4:0] KIND_RPAREN    = 5'd1;
   localparam logic [4:0] KIND_LBRACKET  = 5'd2;
   localparam logic [4:0] KIND_RBRACKET  = 5'd3;
   localparam logic [4:0] KIND_LBRACE    = 5'd4;
   localparam logic [4:0] KIND_RBRACE    = 5'd5;
   localparam logic [4:0] KIND_COMMA     = 5'd6;
   localparam logic [4:0] KIND_SEMICOLON = 5'd7;
   localparam logic [4:0] KIND_COLON     = 5'd8;
   localparam logic [4:0] KIND_PLUS      = 5'd9;
   localparam logic [4:0] KIND_MINUS     = 5'd10;
   localparam logic [4:0] KIND_STAR      = 5'd11;
   localparam logic [4:0] KIND_ASSIGN    = 5'd12;
   localparam logic [4:0] KIND_ID     = 5'd13;
   localparam logic [4:0] KIND_INT    = 5'd14;
   localparam logic [4:0] KIND_STRING = 5'd15;
   localparam logic [4:0] KIND_IF     = 5'd16;
   localparam logic [4:0] KIND_WHILE  = 5'd17;
   localparam logic [4:0] KIND_DEF    = 5'd18;
   localparam logic [4:0] KIND_RET    = 5'd19;
   localparam logic [4:0] KIND_FUN    = 5'd20;
   localparam logic [4:0] KIND_EOF    = 5'd21;
   localparam logic [4:0] KIND_ERROR  = 5'd22;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
   } token_type;

   // one or two tokens raised by a single source byte
   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } pair_type;

endpackage

// ===== src/slxu_front.sv =====
// ----------------------------------------------------------------------------
// slxu_front
// Per-byte classification and lexer state; emits token pairs as tokens finish.
// ----------------------------------------------------------------------------
`include "small_language_lexer_unit_assert.svh"

module slxu_front #(
   parameter int POSITION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         source_byte,
   input  logic               end_of_source,
   output logic               push,
   output slxu_pkg::pair_type push_pair
);

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_ID   = 3'd1;
   localparam logic [2:0] MODE_INT  = 3'd2;
   localparam logic [2:0] MODE_STR  = 3'd3;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;

   logic [2:0]               mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_inc;
   logic [15:0]              start_ff, start_in;
   logic [15:0]              len_ff, len_in, len_sat;
   logic [39:0]              prefix_ff, prefix_in, prefix_ext;
   logic [POSITION_BITS+15:0] pos_wide, inc_wide;
   logic [15:0]              pos16, inc16;
   logic                     ending, is_letter, is_digit, is_space, is_quote;
   logic                     punct_hit;
   logic [4:0]               punct_kind, id_kind;
   logic                     close_v, new_v;
   slxu_pkg::token_type      close_tok, new_tok;

   assign ending    = end_of_source | (source_byte == 8'd0);
   assign is_letter = ((source_byte >= 8'h61) && (source_byte <= 8'h7A)) ||
                      ((source_byte >= 8'h41) && (source_byte <= 8'h5A));
   assign is_digit  = (source_byte >= 8'h30) && (source_byte <= 8'h39);
   assign is_space  = (source_byte == 8'h20) || (source_byte == 8'h09) ||
                      (source_byte == 8'd13) || (source_byte == 8'd10);
   assign is_quote  = (source_byte == CHAR_QUOTE);

   assign pos_inc  = pos_ff + 1'b1;
   assign pos_wide = {16'd0, pos_ff};
   assign inc_wide = {16'd0, pos_inc};
   assign pos16    = pos_wide[15:0];
   assign inc16    = inc_wide[15:0];

   assign len_sat    = (len_ff == 16'hFFFF) ? len_ff : len_ff + 16'd1;
   assign prefix_ext = ((mode_ff == MODE_ID) && (len_ff < 16'd5)) ?
                       {prefix_ff[31:0], source_byte} : prefix_ff;

   always_comb begin
      punct_hit  = 1'b1;
      punct_kind = slxu_pkg::KIND_LPAREN;
      unique case (source_byte)
         8'h28: punct_kind = slxu_pkg::KIND_LPAREN;
         8'h29: punct_kind = slxu_pkg::KIND_RPAREN;
         8'h5B: punct_kind = slxu_pkg::KIND_LBRACKET;
         8'h5D: punct_kind = slxu_pkg::KIND_RBRACKET;
         8'h7B: punct_kind = slxu_pkg::KIND_LBRACE;
         8'h7D: punct_kind = slxu_pkg::KIND_RBRACE;
         8'h2C: punct_kind = slxu_pkg::KIND_COMMA;
         8'h3B: punct_kind = slxu_pkg::KIND_SEMICOLON;
         8'h3A: punct_kind = slxu_pkg::KIND_COLON;
         8'h2B: punct_kind = slxu_pkg::KIND_PLUS;
         8'h2D: punct_kind = slxu_pkg::KIND_MINUS;
         8'h2A: punct_kind = slxu_pkg::KIND_STAR;
         8'h3D: punct_kind = slxu_pkg::KIND_ASSIGN;
         default: punct_hit = 1'b0;
      endcase
   end

   always_comb begin
      id_kind = slxu_pkg::KIND_ID;
      if ((len_ff == 16'd2) && (prefix_ff == 40'h0000006966))
         id_kind = slxu_pkg::KIND_IF;
      else if ((len_ff == 16'd5) && (prefix_ff == 40'h7768696C65))
         id_kind = slxu_pkg::KIND_WHILE;
      else if ((len_ff == 16'd3) && (prefix_ff == 40'h0000646566))
         id_kind = slxu_pkg::KIND_DEF;
      else if ((len_ff == 16'd3) && (prefix_ff == 40'h0000726574))
         id_kind = slxu_pkg::KIND_RET;
      else if ((len_ff == 16'd3) && (prefix_ff == 40'h000066756E))
         id_kind = slxu_pkg::KIND_FUN;
   end

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      prefix_in = prefix_ff;
      close_v   = 1'b0;
      new_v     = 1'b0;
      close_tok.start  = start_ff;
      close_tok.length = len_ff;
      close_tok.kind   = (mode_ff == MODE_ID)  ? id_kind :
                         (mode_ff == MODE_INT) ? slxu_pkg::KIND_INT :
                                                 slxu_pkg::KIND_ERROR;
      new_tok.kind   = slxu_pkg::KIND_ERROR;
      new_tok.start  = pos16;
      new_tok.length = 16'd1;
      if (ending) begin
         close_v        = (mode_ff != MODE_IDLE);
         new_v          = 1'b1;
         new_tok.kind   = slxu_pkg::KIND_EOF;
         new_tok.length = 16'd0;
         mode_in        = MODE_IDLE;
         pos_in         = '0;
         start_in       = 16'd0;
         len_in         = 16'd0;
         prefix_in      = 40'd0;
      end else begin
         pos_in = pos_inc;
         if (mode_ff == MODE_STR) begin
            if (is_quote) begin
               close_v        = 1'b1;
               close_tok.kind = slxu_pkg::KIND_STRING;
               mode_in        = MODE_IDLE;
            end else begin
               len_in = len_sat;
            end
         end else if (((mode_ff == MODE_ID) && is_letter) ||
                      ((mode_ff == MODE_INT) && is_digit)) begin
            len_in    = len_sat;
            prefix_in = prefix_ext;
         end else begin
            close_v = (mode_ff == MODE_ID) || (mode_ff == MODE_INT);
            mode_in = MODE_IDLE;
            if (is_space) begin
               new_v = 1'b0;
            end else if (is_letter) begin
               mode_in   = MODE_ID;
               start_in  = pos16;
               len_in    = 16'd1;
               prefix_in = {32'd0, source_byte};
            end else if (is_digit) begin
               mode_in   = MODE_INT;
               start_in  = pos16;
               len_in    = 16'd1;
               prefix_in = 40'd0;
            end else if (is_quote) begin
               mode_in   = MODE_STR;
               start_in  = inc16;
               len_in    = 16'd0;
               prefix_in = 40'd0;
            end else if (punct_hit) begin
               new_v        = 1'b1;
               new_tok.kind = punct_kind;
            end else begin
               new_v = 1'b1;
            end
         end
      end
   end

   always_comb begin
      push           = accept & (close_v | new_v);
      push_pair.two  = close_v & new_v;
      push_pair.tok0 = close_v ? close_tok : new_tok;
      push_pair.tok1 = new_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         start_ff  <= 16'd0;
         len_ff    <= 16'd0;
         prefix_ff <= 40'd0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         prefix_ff <= prefix_in;
      end
   end

   `SLXU_ASSERT(a_end_resets, clock, reset,
      accept && ending |=> (mode_ff == MODE_IDLE) && (pos_ff == '0))
   `SLXU_NEVER(a_open_len, clock, reset,
      ((mode_ff == MODE_ID) || (mode_ff == MODE_INT)) && (len_ff == 16'd0))
   `SLXU_ASSERT(a_eof_last, clock, reset,
      accept && ending |-> push && (push_pair.two ? push_pair.tok1.kind :
         push_pair.tok0.kind) == slxu_pkg::KIND_EOF)

endmodule

// ===== src/slxu_queue.sv =====
// ----------------------------------------------------------------------------
// slxu_queue
// Small FIFO of token pairs between the classifier and the output stage.
// ----------------------------------------------------------------------------
module slxu_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  slxu_pkg::pair_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output slxu_pkg::pair_type head_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   slxu_pkg::pair_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/slxu_back.sv =====
// ----------------------------------------------------------------------------
// slxu_back
// Output stage: splits token pairs into single result transfers.
// ----------------------------------------------------------------------------
`include "small_language_lexer_unit_assert.svh"

module slxu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  slxu_pkg::pair_type head_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [4:0]         rsp_token_kind,
   output logic [15:0]        rsp_token_start,
   output logic [15:0]        rsp_token_length,
   output logic               rsp_last_of_run
);

   logic                rsp_valid_ff, rsp_valid_in;
   logic                half_ff, half_in;
   logic                last_ff, last_in;
   slxu_pkg::token_type tok_ff, tok_in;
   logic                load;

   assign load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      half_in      = half_ff;
      last_in      = last_ff;
      tok_in       = tok_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            if (head_data.two && !half_ff) begin
               tok_in  = head_data.tok0;
               last_in = 1'b0;
               half_in = 1'b1;
            end else begin
               tok_in  = half_ff ? head_data.tok1 : head_data.tok0;
               last_in = 1'b1;
               half_in = 1'b0;
               pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         half_ff      <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      tok_ff  <= tok_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_kind   = tok_ff.kind;
   assign rsp_token_start  = tok_ff.start;
   assign rsp_token_length = tok_ff.length;
   assign rsp_last_of_run  = last_ff;

   `SLXU_ASSERT(a_half_has_head, clock, reset, half_ff |-> head_valid)
   `SLXU_ASSERT(a_pair_follows, clock, reset,
      rsp_valid_ff && !rsp_stall && !last_ff |=> rsp_valid_ff && last_ff)

endmodule

// ===== src/small_language_lexer_unit.sv =====
// Path: a byte's first token passes the pair queue and the output register
// before it appears on rsp. Throughput: one source byte per cycle while the
// pair queue is not full; the output stage delivers one token per cycle while
// rsp is not stalled, so a byte raising two tokens becomes two transfers.
// Short bursts are absorbed by the pair queue; a steady run of them stalls req.
// Reset: synchronous; lexer returns to idle at offset zero, queue emptied.
// ----------------------------------------------------------------------------
// small_language_lexer_unit
// Streaming lexer: classifies source bytes and emits tokens with offsets.
// ----------------------------------------------------------------------------
module small_language_lexer_unit #(
   parameter int POSITION_BITS = 16,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_source_byte,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);

   logic               accept, push, full, pop, head_valid;
   slxu_pkg::pair_type push_pair, head_data;

   assign req_stall = full;
   assign accept    = req_valid & !full;

   slxu_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .source_byte   (req_source_byte),
      .end_of_source (req_end_of_source),
      .push          (push),
      .push_pair     (push_pair)
   );

   slxu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_pair),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   slxu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_data        (head_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
